// ===== rtl/hcbd_pkg.sv =====
package hcbd_pkg;

    localparam int LEN_BITS = 32;
    localparam int CFG_ADDR_BITS = 3;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_PLAIN   = 3'd0,
        PH_GETLEN  = 3'd1,
        PH_SKIPLEN = 3'd2,
        PH_DATA    = 3'd3,
        PH_SKIPEND = 3'd4,
        PH_NOMORE  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_STRAY_LEN  = 2'd1,
        ST_STRAY_DATA = 2'd2,
        ST_OVERFLOW   = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        REG_CHUNKED_MODE   = 1'b0,
        REG_CONTENT_LENGTH = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic        chunked_mode;
        logic [31:0] content_length;
        logic        restart;
        logic        mode_new;
        logic [31:0] len_new;
    } cfg_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       body_done;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t h;
        h.is_hex = 1'b0;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h37);
        end
        return h;
    endfunction

endpackage

// ===== rtl/hcbd_if.sv =====
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       body_done;
    logic [1:0] status;

    modport source (output valid, output out_valid, output out_byte, output body_done,
                    output status, input ready);
    modport sink (input valid, input out_valid, input out_byte, input body_done,
                  input status, output ready);
endinterface

// ===== rtl/http_chunked_body_decoder_unit.sv =====
// channel   dir  handshake              payload
// body_in   in   valid/ready            data_byte[7:0]
// body_out  out  valid/ready            out_valid, out_byte[7:0], body_done, status[1:0]
// apb       in   psel/penable, pready   paddr[2:0], pwdata/prdata[31:0]
//
// One byte per cycle while body_in is ready; each result is registered in the output buffer before body_out shows it.
// Each byte takes a single combinational decode step from the phase/length registers to its result.
// A two-entry output buffer (head and skid entry) keeps body_in ready until the skid entry fills.
// Reset: plain mode, lengths zero. A register write restarts decoding.
module http_chunked_body_decoder_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hcbd_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    hcbd_in_if.sink                             body_in,
    hcbd_out_if.source                          body_out
);

    hcbd_pkg::cfg_t    cfg;
    hcbd_pkg::result_t result;
    logic              ready;
    logic              accept;

    assign body_in.ready = ready;
    assign accept        = body_in.valid & ready;

    hcbd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hcbd_dec u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .data_byte (body_in.data_byte),
        .result    (result)
    );

    hcbd_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (body_in.valid),
        .in_ready  (ready),
        .in_result (result),
        .body_out  (body_out)
    );

endmodule

// ===== rtl/hcbd_cfg.sv =====
module hcbd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hcbd_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output hcbd_pkg::cfg_t                      cfg
);

    logic        mode_reg;
    logic        mode_next;
    logic [31:0] len_reg;
    logic [31:0] len_next;
    logic        wr_en;
    hcbd_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = hcbd_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        if (wr_en)
        begin
            unique case (idx)
                hcbd_pkg::REG_CHUNKED_MODE:   mode_next = pwdata[0];
                hcbd_pkg::REG_CONTENT_LENGTH: len_next  = pwdata;
                default:                      mode_next = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            hcbd_pkg::REG_CHUNKED_MODE:   prdata = {31'd0, mode_reg};
            hcbd_pkg::REG_CONTENT_LENGTH: prdata = len_reg;
            default:                      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            len_reg  <= 32'd0;
        end
        else
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
        end
    end

    assign cfg.chunked_mode   = mode_reg;
    assign cfg.content_length = len_reg;
    assign cfg.restart        = wr_en;
    assign cfg.mode_new       = mode_next;
    assign cfg.len_new        = len_next;

endmodule

// ===== rtl/hcbd_dec.sv =====
module hcbd_dec (
    input  logic                clk,
    input  logic                rst_n,
    input  hcbd_pkg::cfg_t      cfg,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    output hcbd_pkg::result_t   result
);

    localparam int LB = hcbd_pkg::LEN_BITS;

    hcbd_pkg::phase_t  phase_reg;
    hcbd_pkg::phase_t  phase_next;
    logic [LB-1:0]     chunk_left_reg;
    logic [LB-1:0]     chunk_left_next;
    logic [31:0]       body_left_reg;
    logic [31:0]       body_left_next;
    hcbd_pkg::status_t status;
    hcbd_pkg::hex_t    hex;
    logic              valid;
    logic              done;
    logic [LB-1:0]     chunk_dec;

    assign hex       = hcbd_pkg::hex_digit(data_byte);
    assign chunk_dec = chunk_left_reg - LB'(1);

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        chunk_left_next = chunk_left_reg;
        body_left_next  = body_left_reg;
        status          = hcbd_pkg::ST_OK;
        unique case (phase_reg) inside
            hcbd_pkg::PH_PLAIN:
            begin
                if (cfg.content_length != 32'd0 && body_left_reg != 32'd0)
                    body_left_next = body_left_reg - 32'd1;
            end
            hcbd_pkg::PH_GETLEN, hcbd_pkg::PH_SKIPLEN:
            begin
                if (phase_reg == hcbd_pkg::PH_GETLEN && hex.is_hex)
                begin
                    if (chunk_left_reg[LB-1 -: 4] != 4'd0)
                    begin
                        chunk_left_next = '1;
                        status          = hcbd_pkg::ST_OVERFLOW;
                    end
                    else
                        chunk_left_next = {chunk_left_reg[LB-5:0], hex.value};
                end
                else
                begin
                    phase_next = hcbd_pkg::PH_SKIPLEN;
                    if (data_byte == hcbd_pkg::CHAR_LF)
                        phase_next = (chunk_left_reg != '0) ? hcbd_pkg::PH_DATA
                                                            : hcbd_pkg::PH_NOMORE;
                    else if (data_byte != hcbd_pkg::CHAR_CR &&
                             data_byte != hcbd_pkg::CHAR_SPACE)
                        status = hcbd_pkg::ST_STRAY_LEN;
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                if (chunk_left_reg != '0)
                begin
                    chunk_left_next = chunk_dec;
                    if (chunk_dec == '0)
                        phase_next = hcbd_pkg::PH_SKIPEND;
                end
                else
                    phase_next = hcbd_pkg::PH_SKIPEND;
            end
            hcbd_pkg::PH_SKIPEND:
            begin
                if (data_byte == hcbd_pkg::CHAR_LF)
                begin
                    phase_next      = hcbd_pkg::PH_GETLEN;
                    chunk_left_next = '0;
                end
                else if (data_byte != hcbd_pkg::CHAR_CR)
                    status = hcbd_pkg::ST_STRAY_DATA;
            end
            hcbd_pkg::PH_NOMORE:
            begin
                phase_next = hcbd_pkg::PH_NOMORE;
            end
            default:
            begin
                phase_next      = cfg.chunked_mode ? hcbd_pkg::PH_GETLEN
                                                   : hcbd_pkg::PH_PLAIN;
                chunk_left_next = '0;
                body_left_next  = cfg.content_length;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        valid = (phase_reg == hcbd_pkg::PH_PLAIN) || (phase_reg == hcbd_pkg::PH_DATA);
        if (phase_next == hcbd_pkg::PH_PLAIN)
            done = (cfg.content_length != 32'd0) && (body_left_next == 32'd0);
        else
            done = (phase_next == hcbd_pkg::PH_NOMORE);
        result.out_valid = valid;
        result.out_byte  = valid ? data_byte : 8'd0;
        result.body_done = done;
        result.status    = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= hcbd_pkg::PH_PLAIN;
            chunk_left_reg <= '0;
            body_left_reg  <= 32'd0;
        end
        else if (cfg.restart)
        begin
            phase_reg      <= cfg.mode_new ? hcbd_pkg::PH_GETLEN : hcbd_pkg::PH_PLAIN;
            chunk_left_reg <= '0;
            body_left_reg  <= cfg.len_new;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            chunk_left_reg <= chunk_left_next;
            body_left_reg  <= body_left_next;
        end
    end

`ifndef SYNTHESIS
    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hcbd_pkg::PH_DATA |-> chunk_left_reg != '0)
        else $error("data phase with zero chunk length");

    a_nomore_drops: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hcbd_pkg::PH_NOMORE |-> result.body_done && !result.out_valid)
        else $error("byte passed after final chunk");

    a_restart_load: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.restart |=> chunk_left_reg == '0 && body_left_reg == cfg.content_length)
        else $error("restart did not reload state");

    a_skip_no_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hcbd_pkg::PH_SKIPEND || phase_reg == hcbd_pkg::PH_GETLEN ||
         phase_reg == hcbd_pkg::PH_SKIPLEN) |-> !result.out_valid)
        else $error("framing byte passed as payload");
`endif

endmodule

// ===== rtl/hcbd_obuf.sv =====
module hcbd_obuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hcbd_pkg::result_t  in_result,
    hcbd_out_if.source         body_out
);

    logic              out_v_reg;
    logic              out_v_next;
    hcbd_pkg::result_t out_reg;
    hcbd_pkg::result_t out_next;
    logic              skid_v_reg;
    logic              skid_v_next;
    hcbd_pkg::result_t skid_reg;
    hcbd_pkg::result_t skid_next;
    logic              accept;
    logic              take;

    assign in_ready = !skid_v_reg;
    assign accept   = in_valid & in_ready;
    assign take     = out_v_reg & body_out.ready;

    always_comb
    begin
        out_v_next  = out_v_reg;
        out_next    = out_reg;
        skid_v_next = skid_v_reg;
        skid_next   = skid_reg;
        if (!out_v_reg || take)
        begin
            if (skid_v_reg)
            begin
                out_v_next  = 1'b1;
                out_next    = skid_reg;
                skid_v_next = 1'b0;
            end
            else if (accept)
            begin
                out_v_next = 1'b1;
                out_next   = in_result;
            end
            else
                out_v_next = 1'b0;
        end
        else if (accept)
        begin
            skid_v_next = 1'b1;
            skid_next   = in_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign body_out.valid     = out_v_reg;
    assign body_out.out_valid = out_reg.out_valid;
    assign body_out.out_byte  = out_reg.out_byte;
    assign body_out.body_done = out_reg.body_done;
    assign body_out.status    = out_reg.status;

`ifndef SYNTHESIS
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry without head entry");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg && body_out.ready |=> out_reg == $past(skid_reg))
        else $error("skid entry lost or reordered");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg && !body_out.ready |=> skid_v_reg && $stable(skid_reg))
        else $error("skid entry overwritten");
`endif

endmodule
